>>> hw/rtl/plc_pkg.sv
// Shared types and constants for the peak label cleanup block.
package plc_pkg;

    localparam int MAX_GAP       = 62;
    localparam int RUN_CAP       = 61;
    localparam int GAP_LIMIT_CAP = (MAX_GAP < RUN_CAP) ? MAX_GAP : RUN_CAP;
    localparam int GAP_W         = 6;
    localparam int POS_W         = 3;
    localparam int POS_SAT       = 7;
    localparam int POS_JUDGE     = 2;
    localparam int POS_DESPECKLE = 4;
    localparam int LBL_W         = 2;
    localparam int TDATA_W       = 8;
    localparam int GAP_RESET     = 1;

    typedef logic [LBL_W-1:0] label_t;

    localparam label_t LBL_BG   = 2'd0;
    localparam label_t LBL_PEAK = 2'd1;
    localparam label_t LBL_EXCL = 2'd2;
    localparam label_t LBL_RSVD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_DRAIN_J,
        ST_TAIL_A,
        ST_DRAIN_A,
        ST_TAIL_B,
        ST_DRAIN_B
    } state_t;

    typedef struct packed {
        logic load;
        logic judge;
        logic tail_a;
        logic tail_b;
        logic drain;
        logic drain_final;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic pend_empty;
        logic last_bin;
        logic pos_ge2;
    } stat_t;

endpackage

>>> hw/rtl/plc_ctrl.sv
// Controller state machine that sequences the judge, tail and drain steps.
module plc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  plc_pkg::stat_t stat,
    output plc_pkg::cmd_t  cmd
);

    plc_pkg::state_t state_reg;
    plc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = plc_pkg::ST_JUDGE;
                end
            end
            plc_pkg::ST_JUDGE: begin
                state_next = plc_pkg::ST_DRAIN_J;
            end
            plc_pkg::ST_DRAIN_J: begin
                if (stat.pend_empty) begin
                    if (!stat.last_bin) begin
                        state_next = plc_pkg::ST_IDLE;
                    end else if (stat.pos_ge2) begin
                        state_next = plc_pkg::ST_TAIL_A;
                    end else begin
                        state_next = plc_pkg::ST_TAIL_B;
                    end
                end
            end
            plc_pkg::ST_TAIL_A: begin
                state_next = plc_pkg::ST_DRAIN_A;
            end
            plc_pkg::ST_DRAIN_A: begin
                if (stat.pend_empty) begin
                    state_next = plc_pkg::ST_TAIL_B;
                end
            end
            plc_pkg::ST_TAIL_B: begin
                state_next = plc_pkg::ST_DRAIN_B;
            end
            plc_pkg::ST_DRAIN_B: begin
                if (stat.pend_empty) begin
                    state_next = plc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = plc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            plc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            plc_pkg::ST_JUDGE: begin
                cmd.judge = 1'b1;
            end
            plc_pkg::ST_DRAIN_J, plc_pkg::ST_DRAIN_A: begin
                cmd.drain = 1'b1;
            end
            plc_pkg::ST_TAIL_A: begin
                cmd.tail_a = 1'b1;
            end
            plc_pkg::ST_TAIL_B: begin
                cmd.tail_b = 1'b1;
            end
            plc_pkg::ST_DRAIN_B: begin
                cmd.drain       = 1'b1;
                cmd.drain_final = 1'b1;
                cmd.clear       = stat.pend_empty;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/plc_datapath.sv
// Datapath with lookahead labels, gap run counter, pending results and output register.
module plc_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  plc_pkg::cmd_t               cmd,
    output plc_pkg::stat_t              stat,
    input  plc_pkg::label_t             in_class,
    input  logic                        in_last,
    input  logic                        cfg_we,
    input  logic [plc_pkg::GAP_W-1:0]   cfg_gap,
    output logic                        out_valid,
    input  logic                        out_ready,
    output plc_pkg::label_t             out_label,
    output logic                        out_end
);

    plc_pkg::label_t             in_x_reg;
    logic                        in_last_reg;
    plc_pkg::label_t             la0_reg, la0_next;
    plc_pkg::label_t             la1_reg, la1_next;
    plc_pkg::label_t             prev_reg, prev_next;
    logic [plc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        after_peak_reg, after_peak_next;
    logic [plc_pkg::GAP_W-1:0]   held_reg, held_next;
    logic [plc_pkg::GAP_W-1:0]   min_gap_reg;
    logic [plc_pkg::GAP_W-1:0]   pend_cnt_reg, pend_cnt_next;
    plc_pkg::label_t             pend_lbl_reg, pend_lbl_next;
    logic                        emit_vld_reg, emit_vld_next;
    plc_pkg::label_t             emit_lbl_reg, emit_lbl_next;
    logic                        out_vld_reg, out_vld_next;
    plc_pkg::label_t             out_lbl_reg, out_lbl_next;
    logic                        out_end_reg, out_end_next;

    logic [plc_pkg::GAP_W-1:0]   limit;
    logic [plc_pkg::GAP_W-1:0]   held_inc;
    plc_pkg::label_t             judged;
    plc_pkg::label_t             gap_c;
    logic                        gap_go;
    logic                        gap_final;
    logic                        slot_free;
    logic                        pend_empty;

    assign limit = (min_gap_reg > plc_pkg::GAP_W'(plc_pkg::GAP_LIMIT_CAP))
                   ? plc_pkg::GAP_W'(plc_pkg::GAP_LIMIT_CAP) : min_gap_reg;
    assign held_inc   = held_reg + plc_pkg::GAP_W'(1);
    assign pend_empty = (pend_cnt_reg == '0) && !emit_vld_reg;
    assign slot_free  = !out_vld_reg || out_ready;

    assign stat.pend_empty = pend_empty;
    assign stat.last_bin   = in_last_reg;
    assign stat.pos_ge2    = (pos_reg >= plc_pkg::POS_W'(plc_pkg::POS_JUDGE));

    always_comb begin
        judged = la0_reg;
        if ((la0_reg == plc_pkg::LBL_PEAK) && (pos_reg >= plc_pkg::POS_W'(plc_pkg::POS_DESPECKLE))
            && (prev_reg == plc_pkg::LBL_BG) && (la1_reg == plc_pkg::LBL_BG)) begin
            judged = plc_pkg::LBL_BG;
        end
    end

    always_comb begin
        gap_c     = la0_reg;
        gap_go    = 1'b0;
        gap_final = 1'b0;
        if (cmd.judge) begin
            gap_c  = judged;
            gap_go = (pos_reg >= plc_pkg::POS_W'(plc_pkg::POS_JUDGE));
        end else if (cmd.tail_a) begin
            gap_c  = la0_reg;
            gap_go = 1'b1;
        end else if (cmd.tail_b) begin
            gap_c     = la1_reg;
            gap_go    = 1'b1;
            gap_final = 1'b1;
        end
    end

    always_comb begin
        la0_next        = la0_reg;
        la1_next        = la1_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        after_peak_next = after_peak_reg;
        held_next       = held_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_lbl_next   = pend_lbl_reg;
        emit_vld_next   = emit_vld_reg;
        emit_lbl_next   = emit_lbl_reg;
        out_vld_next    = out_vld_reg && !out_ready;
        out_lbl_next    = out_lbl_reg;
        out_end_next    = out_end_reg;

        if (cmd.judge) begin
            la0_next = la1_reg;
            la1_next = in_x_reg;
            if (pos_reg != plc_pkg::POS_W'(plc_pkg::POS_SAT)) begin
                pos_next = pos_reg + plc_pkg::POS_W'(1);
            end
            if (gap_go) begin
                prev_next = judged;
            end
        end

        if (gap_go) begin
            if (gap_c == plc_pkg::LBL_BG) begin
                if (after_peak_reg) begin
                    if (held_inc > limit) begin
                        pend_cnt_next   = held_inc;
                        pend_lbl_next   = plc_pkg::LBL_BG;
                        after_peak_next = 1'b0;
                        held_next       = '0;
                    end else if (gap_final) begin
                        pend_cnt_next   = held_inc;
                        pend_lbl_next   = plc_pkg::LBL_PEAK;
                        after_peak_next = 1'b0;
                        held_next       = '0;
                    end else begin
                        held_next = held_inc;
                    end
                end else begin
                    emit_vld_next = 1'b1;
                    emit_lbl_next = plc_pkg::LBL_BG;
                end
            end else begin
                if (after_peak_reg) begin
                    pend_cnt_next = held_reg;
                    pend_lbl_next = plc_pkg::LBL_PEAK;
                end
                emit_vld_next   = 1'b1;
                emit_lbl_next   = gap_c;
                after_peak_next = (gap_c == plc_pkg::LBL_PEAK);
                held_next       = '0;
            end
        end

        if (cmd.drain && slot_free && !pend_empty) begin
            out_vld_next = 1'b1;
            if (pend_cnt_reg != '0) begin
                out_lbl_next  = pend_lbl_reg;
                out_end_next  = cmd.drain_final && in_last_reg && !emit_vld_reg
                                && (pend_cnt_reg == plc_pkg::GAP_W'(1));
                pend_cnt_next = pend_cnt_reg - plc_pkg::GAP_W'(1);
            end else begin
                out_lbl_next  = emit_lbl_reg;
                out_end_next  = cmd.drain_final && in_last_reg;
                emit_vld_next = 1'b0;
            end
        end

        if (cmd.clear) begin
            la0_next        = plc_pkg::LBL_BG;
            la1_next        = plc_pkg::LBL_BG;
            prev_next       = plc_pkg::LBL_BG;
            pos_next        = '0;
            after_peak_next = 1'b0;
            held_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_x_reg    <= (in_class == plc_pkg::LBL_RSVD) ? plc_pkg::LBL_EXCL : in_class;
            in_last_reg <= in_last;
        end
        pend_lbl_reg <= pend_lbl_next;
        emit_lbl_reg <= emit_lbl_next;
        out_lbl_reg  <= out_lbl_next;
        out_end_reg  <= out_end_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            la0_reg        <= plc_pkg::LBL_BG;
            la1_reg        <= plc_pkg::LBL_BG;
            prev_reg       <= plc_pkg::LBL_BG;
            pos_reg        <= '0;
            after_peak_reg <= 1'b0;
            held_reg       <= '0;
            min_gap_reg    <= plc_pkg::GAP_W'(plc_pkg::GAP_RESET);
            pend_cnt_reg   <= '0;
            emit_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            la0_reg        <= la0_next;
            la1_reg        <= la1_next;
            prev_reg       <= prev_next;
            pos_reg        <= pos_next;
            after_peak_reg <= after_peak_next;
            held_reg       <= held_next;
            pend_cnt_reg   <= pend_cnt_next;
            emit_vld_reg   <= emit_vld_next;
            out_vld_reg    <= out_vld_next;
            if (cfg_we) begin
                min_gap_reg <= cfg_gap;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_label = out_lbl_reg;
    assign out_end   = out_end_reg;

endmodule

>>> hw/rtl/peak_label_cleanup.sv
// Top level of the peak label cleanup block: despeckle and short gap merge of bin labels.
//
// Usage: one bin label per transaction enters on the s_ channel, s_tlast on the final bin
// of a sequence. Cleaned labels leave in input order on the m_ channel, m_tlast on the
// final label of the sequence. The cfg_ channel writes min_gap, the longest background run
// after a peak that is filled as peak (reset value 1, capped at 61 internally).
// Sequencing: a transaction is accepted in the idle state and judged in the next cycle.
// Its results then move into the single output register one per cycle while that register
// can take them, so the first one shows on m_tvalid after the judge state and a drain step.
// s_tready rises again only when a drain state finds nothing left pending, so a new bin is
// not taken before the last one is through. A final bin adds two tail steps, each followed
// by a drain (one step for a sequence of a single bin), that flush the two lookahead labels
// and any run still held. A bin that closes a held run releases the whole run.
// Reset clears all sequence state, drops any pending output and restores min_gap to 1.
// When the receiver stalls, the output register holds its label and the drain waits;
// s_tready stays low until every result of the current transaction has entered the output
// register.
module peak_label_cleanup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] bin_class, [7:2] zero
    input  logic        s_tlast,   // last_bin
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] bin_label, [7:2] zero
    output logic        m_tlast,   // seq_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // min_gap
);

    plc_pkg::cmd_t   cmd;
    plc_pkg::stat_t  stat;
    plc_pkg::label_t out_label;

    assign cfg_ready = 1'b1;

    plc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_class  (s_tdata[plc_pkg::LBL_W-1:0]),
        .in_last   (s_tlast),
        .cfg_we    (cfg_valid),
        .cfg_gap   (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_label (out_label),
        .out_end   (m_tlast)
    );

    assign m_tdata = {{(plc_pkg::TDATA_W - plc_pkg::LBL_W){1'b0}}, out_label};

endmodule

>>> hw/rtl/plc_checker.sv
// Port-level checker for the peak label cleanup block, bound to the top level.
module plc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Output transaction changed while stalled.");

    a_label_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0) && (m_tdata[1:0] != 2'd3))
        else $error("Output label carries an undefined code.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input taken again before the previous transaction was processed.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

endmodule

bind peak_label_cleanup plc_checker u_plc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/sv/peak_label_cleanup_test.sv
// Self-checking stream testbench for the peak label cleanup block.
module peak_label_cleanup_test;
    import plc_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int PHASE_BINS    = 32;
    localparam int PRESSURE_AT   = 60;
    localparam int PRESSURE_LEN  = 240;
    localparam int REPORT_MAX    = 10;
    localparam int NUM_PHASES    = 5;

    typedef struct packed {
        label_t lbl;
        logic   seq_end;
    } clean_label_t;

    typedef struct packed {
        label_t cls;
        logic   last;
        logic   typed;
        label_t want;
    } bin_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [GAP_W-1:0]      cfg_data;

    peak_label_cleanup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Single-bin sequences come out unchanged (a reserved code as excluded), so their results are typed in.
    bin_row_t directed_rows [24] = '{
        '{LBL_BG,   1'b1, 1'b1, LBL_BG},
        '{LBL_PEAK, 1'b1, 1'b1, LBL_PEAK},
        '{LBL_EXCL, 1'b1, 1'b1, LBL_EXCL},
        '{LBL_RSVD, 1'b1, 1'b1, LBL_EXCL},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_PEAK, 1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b1, 1'b0, LBL_BG},
        '{LBL_EXCL, 1'b0, 1'b0, LBL_BG},
        '{LBL_PEAK, 1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b1, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_PEAK, 1'b1, 1'b0, LBL_BG},
        '{LBL_PEAK, 1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_PEAK, 1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_BG,   1'b0, 1'b0, LBL_BG},
        '{LBL_EXCL, 1'b1, 1'b0, LBL_BG},
        '{LBL_PEAK, 1'b0, 1'b0, LBL_BG},
        '{LBL_RSVD, 1'b1, 1'b0, LBL_BG}
    };

    logic [GAP_W-1:0] phase_gaps [NUM_PHASES] = '{6'd0, 6'd63, 6'd5, 6'd62, 6'd1};

    clean_label_t cleaned_labels_due [$];
    clean_label_t step_out [$];
    label_t       seq_plan [$];

    label_t           raw_pair [2];
    int unsigned      bins_in_seq;
    bit               run_open;
    int unsigned      run_held;
    label_t           prior_judged;
    logic [GAP_W-1:0] min_gap_shadow;

    int unsigned mismatches;
    int unsigned labels_checked;
    int unsigned bins_sent;
    int unsigned seqs_sent;
    int unsigned rx_hold;
    int unsigned rx_calm;
    bit          pressure_done;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    function automatic label_t random_class();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 9) return LBL_BG;
        if (r < 15) return LBL_PEAK;
        if (r < 18) return LBL_EXCL;
        return LBL_RSVD;
    endfunction

    function automatic int unsigned active_gap_limit();
        return (min_gap_shadow < GAP_LIMIT_CAP) ? min_gap_shadow : GAP_LIMIT_CAP;
    endfunction

    task automatic add_due(clean_label_t item);
        cleaned_labels_due.insert(cleaned_labels_due.size(), item);
    endtask

    task automatic add_plan(label_t l);
        seq_plan.insert(seq_plan.size(), l);
    endtask

    task automatic clear_sequence_state();
        raw_pair[0]  = LBL_BG;
        raw_pair[1]  = LBL_BG;
        bins_in_seq  = 0;
        run_open     = 1'b0;
        run_held     = 0;
        prior_judged = LBL_BG;
    endtask

    task automatic put_label(label_t l);
        step_out.insert(step_out.size(), '{lbl: l, seq_end: 1'b0});
    endtask

    task automatic release_run(label_t l);
        repeat (run_held) put_label(l);
        run_held = 0;
    endtask

    task automatic merge_gaps(label_t c);
        if (c == LBL_BG) begin
            if (run_open) begin
                run_held++;
                if (run_held > active_gap_limit()) begin
                    release_run(LBL_BG);
                    run_open = 1'b0;
                end
            end else begin
                put_label(LBL_BG);
            end
        end else begin
            if (run_open) release_run(LBL_PEAK);
            put_label(c);
            run_open = (c == LBL_PEAK);
        end
    endtask

    task automatic predict_cleanup(label_t cls, logic last);
        label_t x;
        label_t c;
        x = (cls == LBL_RSVD) ? LBL_EXCL : cls;
        step_out.delete();
        if (bins_in_seq >= POS_JUDGE) begin
            c = raw_pair[0];
            if (c == LBL_PEAK && bins_in_seq >= POS_DESPECKLE && prior_judged == LBL_BG
                    && raw_pair[1] == LBL_BG)
                c = LBL_BG;
            prior_judged = c;
            merge_gaps(c);
        end
        raw_pair[0] = raw_pair[1];
        raw_pair[1] = x;
        if (bins_in_seq < POS_SAT) bins_in_seq++;
        if (last) begin
            if (bins_in_seq >= POS_JUDGE) merge_gaps(raw_pair[0]);
            merge_gaps(raw_pair[1]);
            if (run_open) release_run(LBL_PEAK);
            if (step_out.size() > 0) step_out[step_out.size() - 1].seq_end = 1'b1;
            clear_sequence_state();
        end
    endtask

    // Entered and left at a falling edge; s_tvalid is assigned once per edge.
    task automatic send_bin(label_t cls, logic last, logic typed, label_t want, bit calm);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(cls);
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        predict_cleanup(cls, last);
        if (typed) begin
            add_due('{lbl: want, seq_end: 1'b1});
        end else begin
            foreach (step_out[i]) add_due(step_out[i]);
        end
        bins_sent++;
        if (last) seqs_sent++;
        @(negedge aclk);
    endtask

    task automatic build_sequence();
        int unsigned lim;
        int unsigned run;
        lim = active_gap_limit();
        seq_plan.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) add_plan(label_t'($urandom_range(0, 3)));
            return;
        end
        repeat ($urandom_range(0, 3)) add_plan(random_class());
        repeat ($urandom_range(1, 4)) begin
            add_plan(LBL_PEAK);
            if ($urandom_range(0, 3) == 0 && (lim <= 8 || $urandom_range(0, 5) == 0))
                run = lim + $urandom_range(0, 1);
            else
                run = $urandom_range(0, 3);
            repeat (run) add_plan(LBL_BG);
            case ($urandom_range(0, 4))
                0: ;
                1: add_plan(LBL_EXCL);
                2: add_plan(LBL_RSVD);
                3: begin
                    add_plan(LBL_BG);
                    add_plan(LBL_PEAK);
                    add_plan(LBL_BG);
                end
                default: add_plan(random_class());
            endcase
        end
    endtask

    task automatic run_phase(int unsigned bin_budget);
        int unsigned sent;
        bit calm;
        sent = 0;
        while (sent < bin_budget) begin
            build_sequence();
            calm = ($urandom_range(0, 3) == 0);
            foreach (seq_plan[i])
                send_bin(seq_plan[i], i == seq_plan.size() - 1, 1'b0, LBL_BG, calm);
            sent += seq_plan.size();
        end
    endtask

    task automatic write_min_gap(logic [GAP_W-1:0] value);
        s_tvalid <= 1'b0;
        while (cleaned_labels_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        min_gap_shadow = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        m_tready      = 1'b0;
        rx_hold       = 0;
        rx_calm       = 0;
        pressure_done = 1'b0;
    end

    always @(negedge aclk) begin
        if (!pressure_done && labels_checked >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            rx_hold = PRESSURE_LEN;
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_calm > 0) begin
            m_tready <= 1'b1;
            rx_calm--;
        end else begin
            if ($urandom_range(0, 63) == 0) rx_calm = $urandom_range(20, 80);
            rx_hold = pick_gap();
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        clean_label_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (cleaned_labels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected label transaction: tdata=%0h tlast=%0b",
                             m_tdata, m_tlast);
            end else begin
                want = cleaned_labels_due.pop_front();
                labels_checked++;
                if (m_tdata !== TDATA_W'(want.lbl) || m_tlast !== want.seq_end) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("label %0d: expected label=%0d tlast=%0b, got tdata=%0h tlast=%0b",
                                 labels_checked, want.lbl, want.seq_end, m_tdata, m_tlast);
                end
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_MAX) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d labels still due",
                 WATCHDOG_MAX, cleaned_labels_due.size());
        $display("peak_label_cleanup: mismatch");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatches     = 0;
        labels_checked = 0;
        bins_sent      = 0;
        seqs_sent      = 0;
        min_gap_shadow = GAP_W'(GAP_RESET);
        clear_sequence_state();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_bin(directed_rows[i].cls, directed_rows[i].last, directed_rows[i].typed,
                     directed_rows[i].want, 1'b0);

        foreach (phase_gaps[p]) begin
            write_min_gap(phase_gaps[p]);
            run_phase(PHASE_BINS);
        end

        s_tvalid <= 1'b0;
        while (cleaned_labels_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d bins in %0d sequences; %0d cleaned labels checked.",
                 bins_sent, seqs_sent, labels_checked);
        $display("Gap limits 1, 0, 63, 5, 62 and 1 were used, with one long output stall.");
        if (mismatches == 0 && cleaned_labels_due.size() == 0) begin
            $display("peak_label_cleanup: match");
        end else begin
            $display("%0d mismatches, %0d labels still due", mismatches,
                     cleaned_labels_due.size());
            $display("peak_label_cleanup: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/plc_pkg.sv
hw/rtl/plc_ctrl.sv
hw/rtl/plc_datapath.sv
hw/rtl/peak_label_cleanup.sv
hw/rtl/plc_checker.sv
tb/sv/peak_label_cleanup_test.sv
